// ===== rtl/core/fcr_pkg.sv =====
// Package for the framed command receiver: payload structs, state and
// configuration types, register indexes, reset values and the gain decode.
// No dependencies.
package fcr_pkg;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_ERROR = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    PH_PREAMBLE = 2'd0,
    PH_DATA     = 2'd1,
    PH_TERM     = 2'd2
  } phase_e;

  localparam logic [1:0] CFG_PREAMBLE   = 2'd0;
  localparam logic [1:0] CFG_TERMINATOR = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0]  PreambleRst   = 8'h24;
  localparam logic [7:0]  TerminatorRst = 8'h0A;
  localparam logic [15:0] TimeoutRst    = 16'd50;

  localparam logic [7:0]  CmdLedOff = 8'h00;
  localparam logic [7:0]  CmdLedOn  = 8'h01;
  localparam logic [7:0]  CmdGain2  = 8'h02;
  localparam logic [7:0]  CmdGain4  = 8'h04;
  localparam logic [7:0]  CmdGain8  = 8'h08;
  localparam logic [7:0]  CmdGain16 = 8'h10;

  localparam logic [1:0] GAIN_X2  = 2'd0;
  localparam logic [1:0] GAIN_X4  = 2'd1;
  localparam logic [1:0] GAIN_X8  = 2'd2;
  localparam logic [1:0] GAIN_X16 = 2'd3;

  localparam logic [15:0] IdleMax = 16'hFFFF;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       frame_done;
    logic [7:0] command;
    logic       led_on;
    logic [1:0] gain_code;
    logic       gain_updated;
    logic       in_frame;
    logic       timed_out;
  } out_t;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  held_data;
    logic [15:0] idle_count;
    logic        led_level;
    logic [1:0]  gain_select;
  } state_t;

  typedef struct packed {
    logic [7:0]  preamble_byte;
    logic [7:0]  terminator_byte;
    logic [15:0] timeout_ticks;
  } cfg_t;

  function automatic logic [1:0] gain_of_command(input logic [7:0] cmd);
    logic [1:0] g;
    unique case (cmd)
      CmdGain2:  g = GAIN_X2;
      CmdGain4:  g = GAIN_X4;
      CmdGain8:  g = GAIN_X8;
      CmdGain16: g = GAIN_X16;
      default:   g = GAIN_X16;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/core/framed_command_receiver_top.sv =====
// Top level of the framed command receiver: input register, state,
// configuration registers and result register.
// Depends on fcr_pkg and fcr_decode.
//
// Each input transaction (received byte, line error, millisecond tick or
// no-op) yields exactly one result transaction. A transaction is captured
// in the input register, decoded against the frame state combinationally
// and written to the result register, so the block takes one transaction
// per cycle while the output is not stalled. The input side keeps
// accepting while a result waits, up to one transaction held in each
// register. Configuration registers (preamble, terminator, timeout) are to
// be written through cfg_we_i only while no transaction is in flight; the
// block does not enforce this. Writes to index 3 are ignored.
module framed_command_receiver_top import fcr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t   cfg_q;
  state_t st_q, st_d;
  in_t    item_q;
  logic   item_vld_q;
  out_t   res_q, res_d;
  logic   res_vld_q;
  logic   advance;

  assign advance    = item_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !item_vld_q || advance;

  fcr_decode u_decode (
    .st_i   (st_q),
    .cfg_i  (cfg_q),
    .item_i (item_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.preamble_byte   <= PreambleRst;
      cfg_q.terminator_byte <= TerminatorRst;
      cfg_q.timeout_ticks   <= TimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_PREAMBLE:   cfg_q.preamble_byte   <= cfg_wdata_i[7:0];
        CFG_TERMINATOR: cfg_q.terminator_byte <= cfg_wdata_i[7:0];
        CFG_TIMEOUT:    cfg_q.timeout_ticks   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase       <= PH_PREAMBLE;
      st_q.held_data   <= '0;
      st_q.idle_count  <= '0;
      st_q.led_level   <= 1'b0;
      st_q.gain_select <= GAIN_X16;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_vld_q <= in_valid_i;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_data_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

endmodule

// ===== rtl/core/fcr_decode.sv =====
// Next-state and result logic for one receiver transaction.
// Depends on fcr_pkg.
module fcr_decode import fcr_pkg::*; (
  input  state_t st_i,
  input  cfg_t   cfg_i,
  input  in_t    item_i,
  output state_t st_o,
  output out_t   res_o
);

  logic [15:0] idle_inc;
  logic        done;
  logic        gain_upd;
  logic        tmo;

  assign idle_inc = (st_i.idle_count == IdleMax) ? st_i.idle_count
                                                 : st_i.idle_count + 16'd1;

  always_comb begin
    st_o     = st_i;
    done     = 1'b0;
    gain_upd = 1'b0;
    tmo      = 1'b0;
    unique case (opcode_e'(item_i.opcode))
      OP_BYTE: begin
        st_o.idle_count = '0;
        unique case (st_i.phase)
          PH_DATA: begin
            st_o.held_data = item_i.rx_byte;
            st_o.phase     = PH_TERM;
          end
          PH_TERM: begin
            if (item_i.rx_byte == cfg_i.terminator_byte) begin
              done = 1'b1;
              if (st_i.held_data == CmdLedOn) begin
                st_o.led_level = 1'b1;
              end else if (st_i.held_data == CmdLedOff) begin
                st_o.led_level = 1'b0;
              end else begin
                st_o.gain_select = gain_of_command(st_i.held_data);
                gain_upd         = 1'b1;
              end
            end
            st_o.phase = PH_PREAMBLE;
          end
          default: begin
            st_o.phase = (item_i.rx_byte == cfg_i.preamble_byte) ? PH_DATA : PH_PREAMBLE;
          end
        endcase
      end
      OP_ERROR: begin
        st_o.phase = PH_PREAMBLE;
      end
      OP_TICK: begin
        st_o.idle_count = idle_inc;
        if (st_i.phase != PH_PREAMBLE && idle_inc > cfg_i.timeout_ticks) begin
          st_o.phase = PH_PREAMBLE;
          tmo        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.frame_done   = done;
  assign res_o.command      = st_o.held_data;
  assign res_o.led_on       = st_o.led_level;
  assign res_o.gain_code    = st_o.gain_select;
  assign res_o.gain_updated = gain_upd;
  assign res_o.in_frame     = (st_o.phase != PH_PREAMBLE);
  assign res_o.timed_out    = tmo;

endmodule

// ===== tb/sv/framed_command_receiver_top_tb.sv =====
// Testbench for framed_command_receiver_top: directed and random event streams
// checked result by result against an in-bench frame decoder.
// Depends on fcr_pkg and the framed_command_receiver_top RTL.
module framed_command_receiver_top_tb;
  import fcr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod = 12;
  localparam int QuietLimit = 2000;
  localparam logic [1:0] CfgUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  framed_command_receiver_top dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // decoder copy: configuration and frame state
  logic [7:0] cfg_pre = PreambleRst;
  logic [7:0] cfg_term = TerminatorRst;
  logic [15:0] cfg_timeout = TimeoutRst;
  phase_e cur_phase = PH_PREAMBLE;
  logic [7:0] held_byte = '0;
  logic [15:0] idle_cnt = '0;
  logic led_lvl = 1'b0;
  logic [1:0] gain_sel = GAIN_X16;

  in_t event_q[$];
  out_t expected_results[$];
  int queued_count = 0;
  int accepted_count = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int in_idle_pct = 29;
  int out_idle_pct = 29;
  int hold_request = 0;
  int hold_left = 0;
  logic in_taken = 1'b0;

  task automatic decode_event(input in_t ev, output out_t res);
    logic done, upd, tmo;
    done = 1'b0;
    upd = 1'b0;
    tmo = 1'b0;
    case (ev.opcode)
      OP_BYTE: begin
        idle_cnt = '0;
        case (cur_phase)
          PH_DATA: begin
            held_byte = ev.rx_byte;
            cur_phase = PH_TERM;
          end
          PH_TERM: begin
            if (ev.rx_byte == cfg_term) begin
              done = 1'b1;
              if (held_byte == CmdLedOn) begin
                led_lvl = 1'b1;
              end else if (held_byte == CmdLedOff) begin
                led_lvl = 1'b0;
              end else begin
                upd = 1'b1;
                case (held_byte)
                  CmdGain2: gain_sel = GAIN_X2;
                  CmdGain4: gain_sel = GAIN_X4;
                  CmdGain8: gain_sel = GAIN_X8;
                  default: gain_sel = GAIN_X16;
                endcase
              end
            end
            cur_phase = PH_PREAMBLE;
          end
          default: cur_phase = (ev.rx_byte == cfg_pre) ? PH_DATA : PH_PREAMBLE;
        endcase
      end
      OP_ERROR: cur_phase = PH_PREAMBLE;
      OP_TICK: begin
        if (idle_cnt != IdleMax) idle_cnt = idle_cnt + 16'd1;
        if (cur_phase != PH_PREAMBLE && idle_cnt > cfg_timeout) begin
          cur_phase = PH_PREAMBLE;
          tmo = 1'b1;
        end
      end
      default: ;
    endcase
    res.frame_done = done;
    res.command = held_byte;
    res.led_on = led_lvl;
    res.gain_code = gain_sel;
    res.gain_updated = upd;
    res.in_frame = (cur_phase != PH_PREAMBLE);
    res.timed_out = tmo;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic push(input logic [1:0] op, input logic [7:0] b);
    in_t ev;
    ev.opcode = op;
    ev.rx_byte = b;
    event_q.push_back(ev);
    queued_count++;
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= data;
    case (addr)
      CFG_PREAMBLE: cfg_pre = data[7:0];
      CFG_TERMINATOR: cfg_term = data[7:0];
      CFG_TIMEOUT: cfg_timeout = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain;
    while (event_q.size() != 0 || accepted_count != queued_count ||
           expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic gen_traffic(input int n_items, input int max_burst);
    int start;
    int pick;
    logic [7:0] data;
    start = queued_count;
    while (queued_count - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        push(OP_BYTE, cfg_pre);
        if ($urandom_range(0, 99) < 12) push_ticks($urandom_range(1, max_burst));
        case ($urandom_range(0, 7))
          0: data = CmdLedOff;
          1: data = CmdLedOn;
          2: data = CmdGain2;
          3: data = CmdGain4;
          4: data = CmdGain8;
          5: data = CmdGain16;
          default: data = 8'($urandom_range(0, 255));
        endcase
        push(OP_BYTE, data);
        if ($urandom_range(0, 99) < 12) push_ticks($urandom_range(1, max_burst));
        if ($urandom_range(0, 99) < 6) push(OP_ERROR, 8'($urandom_range(0, 255)));
        push(OP_BYTE, ($urandom_range(0, 99) < 88) ? cfg_term : 8'($urandom_range(0, 255)));
      end else if (pick < 70) begin
        push_ticks($urandom_range(1, max_burst));
      end else if (pick < 80) begin
        push(OP_ERROR, 8'($urandom_range(0, 255)));
      end else if (pick < 86) begin
        push(OP_NONE, 8'($urandom_range(0, 255)));
      end else begin
        push(OP_BYTE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (event_q.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          in_data_i <= event_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      in_taken = 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_request > 0) begin
        hold_left = hold_request - 1;
        hold_request = 0;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    out_t want;
    out_t pred;
    logic fired;
    if (rst_ni) begin
      fired = 1'b0;
      if (out_valid_o && out_ready_i) begin
        fired = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result transaction with no expectation pending");
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("frame_done", want.frame_done, out_data_o.frame_done);
          check_field("command", want.command, out_data_o.command);
          check_field("led_on", want.led_on, out_data_o.led_on);
          check_field("gain_code", want.gain_code, out_data_o.gain_code);
          check_field("gain_updated", want.gain_updated, out_data_o.gain_updated);
          check_field("in_frame", want.in_frame, out_data_o.in_frame);
          check_field("timed_out", want.timed_out, out_data_o.timed_out);
        end
      end
      if (in_valid_i && in_ready_o) begin
        fired = 1'b1;
        decode_event(in_data_i, pred);
        expected_results.push_back(pred);
        accepted_count++;
        in_taken = 1'b1;
      end
      quiet_cycles = fired ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (rst_ni);
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : sequencer
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push(OP_BYTE, PreambleRst);
    push(OP_BYTE, CmdLedOn);
    push(OP_BYTE, TerminatorRst);
    push(OP_BYTE, PreambleRst);
    push(OP_BYTE, CmdLedOff);
    push(OP_BYTE, TerminatorRst);
    push(OP_BYTE, PreambleRst);
    push(OP_BYTE, CmdGain2);
    push(OP_BYTE, TerminatorRst);
    push(OP_BYTE, PreambleRst);
    push(OP_BYTE, CmdGain16);
    push(OP_BYTE, TerminatorRst);
    push(OP_BYTE, PreambleRst);
    push(OP_BYTE, 8'hFF);
    push(OP_BYTE, TerminatorRst);
    push(OP_BYTE, PreambleRst);
    push(OP_BYTE, CmdGain8);
    push(OP_BYTE, TerminatorRst + 8'd1);
    push(OP_BYTE, PreambleRst);
    push(OP_ERROR, 8'hFF);
    push(OP_BYTE, TerminatorRst);
    push(OP_NONE, 8'hFF);
    push(OP_TICK, 8'h00);
    drain();

    write_reg(CFG_PREAMBLE, {8'($urandom_range(0, 255)), 8'h00});
    write_reg(CFG_TERMINATOR, {8'($urandom_range(0, 255)), 8'hFF});
    write_reg(CFG_TIMEOUT, 16'd0);
    write_reg(CfgUnused, 16'($urandom_range(0, 65535)));
    push(OP_BYTE, cfg_pre);
    push(OP_TICK, 8'hFF);
    gen_traffic(350, 4);
    drain();

    write_reg(CFG_PREAMBLE, {8'($urandom_range(0, 255)), 8'hFF});
    write_reg(CFG_TERMINATOR, 16'h0000);
    write_reg(CFG_TIMEOUT, 16'd3);
    hold_request = 80;
    gen_traffic(400, 8);
    drain();

    in_idle_pct = 0;
    out_idle_pct = 0;
    write_reg(CFG_PREAMBLE, 16'($urandom_range(0, 65535)));
    write_reg(CFG_TERMINATOR, 16'($urandom_range(0, 65535)));
    write_reg(CFG_TIMEOUT, 16'($urandom_range(1, 12)));
    gen_traffic(400, 16);
    drain();

    in_idle_pct = 29;
    out_idle_pct = 29;
    write_reg(CFG_PREAMBLE, 16'(PreambleRst));
    write_reg(CFG_TERMINATOR, 16'(TerminatorRst));
    write_reg(CFG_TIMEOUT, TimeoutRst);
    gen_traffic(650, 60);
    drain();

    in_idle_pct = 0;
    out_idle_pct = 0;
    write_reg(CFG_TIMEOUT, 16'd65534);
    push(OP_BYTE, cfg_pre);
    push_ticks(40);
    push(OP_BYTE, cfg_pre);
    push(OP_BYTE, CmdGain4);
    push(OP_BYTE, cfg_term);
    drain();

    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
